>>> src/sdf_pkg.sv
// Shared constants, codes and types for the smoothed second-derivative filter.
`timescale 1ns / 1ps
package sdf_pkg;
	localparam int DATA_W    = 16;
	localparam int IDX_W     = 16;
	localparam int DERIV_W   = 32;
	localparam int CFG_W     = 16;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	// seven-tap interior filter, results trail the input by six samples
	localparam int DELAY     = 6;
	localparam int WIN_DEPTH = 10;
	localparam int SEL_W     = 3;
	localparam int TAP_W     = 4;
	localparam int SUM_W     = 20;
	localparam int MAG_W     = 19;
	localparam int PROD_W    = MAG_W + CFG_W;
	localparam int SH_W      = 4;

	localparam logic [PADDR_W-1:0] ADDR_INV_DX_SQ = 3'd0;
	localparam logic [CFG_W-1:0]   INV_DX_SQ_RST  = 16'd256;

	// filter kind for one result
	localparam logic [2:0] KIND_END_L = 3'd0;
	localparam logic [2:0] KIND_END_R = 3'd1;
	localparam logic [2:0] KIND_M1    = 3'd2;
	localparam logic [2:0] KIND_M2    = 3'd3;
	localparam logic [2:0] KIND_M3    = 3'd4;
	localparam logic [2:0] KIND_SHORT = 3'd5;

	typedef logic signed [DATA_W-1:0] smp_t;

	typedef struct packed {
		logic             vld;
		logic [SEL_W-1:0] d;
		logic [IDX_W-1:0] idx;
		logic [2:0]       kind;
		logic             fin;
	} issue_t;

	typedef struct packed {
		logic                      vld;
		logic signed [DERIV_W-1:0] deriv;
		logic [IDX_W-1:0]          idx;
		logic                      too_short;
		logic                      fin;
	} res_t;
endpackage

>>> src/sdf_if.sv
// Stream interfaces for sample words and result words.
`timescale 1ns / 1ps
interface sdf_smp_if;
	import sdf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  sample;
	logic                      last;
	modport source(output valid, sample, last, input ready);
	modport sink(input valid, sample, last, output ready);
endinterface

interface sdf_res_if;
	import sdf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DERIV_W-1:0] deriv;
	logic [IDX_W-1:0]          index;
	logic                      too_short;
	logic                      final_res;
	modport source(output valid, deriv, index, too_short, final_res, input ready);
	modport sink(input valid, deriv, index, too_short, final_res, output ready);
endinterface

>>> src/sdf_cell.sv
// One window cell: holds a sample and passes it on when a new word enters.
`timescale 1ns / 1ps
module sdf_cell (
	input  logic          clk,
	input  logic          shift,
	input  sdf_pkg::smp_t d_in,
	output sdf_pkg::smp_t d_out
);
	import sdf_pkg::*;

	smp_t val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d_in;
		end
	end

	assign d_out = val_q;
endmodule

>>> src/sdf_arith.sv
// Tap sum, scaling multiply and rounding/saturation, three registered stages.
`timescale 1ns / 1ps
module sdf_arith (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  sdf_pkg::issue_t           iss,
	input  sdf_pkg::smp_t             taps [sdf_pkg::WIN_DEPTH],
	input  logic [sdf_pkg::CFG_W-1:0] inv_dx_sq,
	output sdf_pkg::res_t             res
);
	import sdf_pkg::*;

	logic [TAP_W-1:0]        ic;
	logic signed [SUM_W-1:0] c, p1, p2, p3, n1, n2, n3, sum;
	logic [SH_W-1:0]         sh;

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [SUM_W-1:0] sum_s1;
	logic [SH_W-1:0]         sh_s1, sh_s2;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic                    short_s1, short_s2, short_s3;
	logic                    fin_s1, fin_s2, fin_s3;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod_s2;
	logic                    neg_s2;
	logic [PROD_W:0]         rnd, rsh;
	logic signed [DERIV_W-1:0] dv, deriv_s3;

	// cell d holds the centre point; lower cells are later samples
	always_comb begin
		ic = {1'b0, iss.d};
		c  = SUM_W'(taps[ic]);
		p1 = (iss.d >= 3'd1) ? SUM_W'(taps[ic - 4'd1]) : '0;
		p2 = (iss.d >= 3'd2) ? SUM_W'(taps[ic - 4'd2]) : '0;
		p3 = (iss.d >= 3'd3) ? SUM_W'(taps[ic - 4'd3]) : '0;
		n1 = SUM_W'(taps[ic + 4'd1]);
		n2 = SUM_W'(taps[ic + 4'd2]);
		n3 = SUM_W'(taps[ic + 4'd3]);
		sum = '0;
		sh  = 4'd8;
		unique case (iss.kind)
			KIND_END_L: sum = (c <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
			KIND_END_R: sum = (c <<< 1) - (n1 <<< 2) - n1 + (n2 <<< 2) - n3;
			KIND_M1:    sum = p1 + n1 - (c <<< 1);
			KIND_M2: begin
				sum = p2 + n2 - (c <<< 1);
				sh  = 4'd10;
			end
			KIND_M3: begin
				sum = ((p2 + n2) <<< 1) + p3 + n3 - p1 - n1 - (c <<< 2);
				sh  = 4'd12;
			end
			default: sum = '0;
		endcase
	end

	assign mag = sum_s1[SUM_W-1] ? MAG_W'(-sum_s1) : MAG_W'(sum_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= iss.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1   <= sum;
			sh_s1    <= sh;
			idx_s1   <= iss.idx;
			short_s1 <= (iss.kind == KIND_SHORT);
			fin_s1   <= iss.fin;
			prod_s2  <= PROD_W'(mag) * PROD_W'(inv_dx_sq);
			neg_s2   <= sum_s1[SUM_W-1];
			sh_s2    <= sh_s1;
			idx_s2   <= idx_s1;
			short_s2 <= short_s1;
			fin_s2   <= fin_s1;
			deriv_s3 <= dv;
			idx_s3   <= idx_s2;
			short_s3 <= short_s2;
			fin_s3   <= fin_s2;
		end
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		rnd = {1'b0, prod_s2} + ((PROD_W+1)'(1) << (sh_s2 - 4'd1));
		rsh = rnd >> sh_s2;
		if (short_s2) begin
			dv = '0;
		end else if (neg_s2) begin
			dv = (rsh > (PROD_W+1)'(33'h080000000)) ? {1'b1, {(DERIV_W-1){1'b0}}}
				: -DERIV_W'(rsh);
		end else begin
			dv = (rsh > (PROD_W+1)'(33'h07FFFFFFF)) ? {1'b0, {(DERIV_W-1){1'b1}}}
				: DERIV_W'(rsh);
		end
	end

	assign res.vld       = vld_s3;
	assign res.deriv     = deriv_s3;
	assign res.idx       = idx_s3;
	assign res.too_short = short_s3;
	assign res.fin       = fin_s3;
endmodule

>>> src/smooth_second_derivative_filter.sv
// Top level: sample window cell chain, flush sequencer, arithmetic and APB register.
//
// Samples of a vector enter on in_ch (valid/ready), index order, last on the final word.
// Results leave on out_ch: deriv, index, too_short, final_res, in index order.
// The result for index i is computed once sample i+6 has arrived and reaches out_ch
// via the issue register and the sdf_arith stages. A vector of seven or more words ends
// in a flush: its last word and the flush issue the last seven results, one a cycle, with
// in_ch held not ready; otherwise one word is taken per cycle. Both halt if out_ch stalls.
// A vector of six words or fewer gives a single word with too_short set and deriv 0.
// A vector reaching 65536 words is closed as if last were set on its final word.
// inv_dx_sq (Q8.8, address 0) is written over APB; reset value 1.0.
// Reset clears the position count, flush state and pipeline valids; no window clear.
// When out_ch stalls the whole pipe holds and in_ch drops ready; the output word stays.
`timescale 1ns / 1ps
module smooth_second_derivative_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	sdf_smp_if.sink                       in_ch,
	sdf_res_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sdf_pkg::PADDR_W-1:0]   paddr,
	input  logic [sdf_pkg::PDATA_W-1:0]   pwdata,
	output logic [sdf_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import sdf_pkg::*;

	logic [CFG_W-1:0] inv_q;
	logic [IDX_W-1:0] pos_q, last_q;
	logic             flush_q;
	logic [SEL_W-1:0] fd_q;
	issue_t           issue, iss_s0;
	res_t             res;
	smp_t             taps [WIN_DEPTH];
	logic             adv, acc, fin;

	function automatic logic [2:0] kind_of(input logic [IDX_W-1:0] i, input logic [3:0] r);
		logic [IDX_W-1:0] e;
		e = ({12'd0, r} < i) ? {12'd0, r} : i;
		if (i == '0)
			return KIND_END_L;
		else if (r == 4'd0)
			return KIND_END_R;
		else if (e == 16'd1)
			return KIND_M1;
		else if (e == 16'd2)
			return KIND_M2;
		else
			return KIND_M3;
	endfunction

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_INV_DX_SQ) ? PDATA_W'(inv_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_DX_SQ_RST;
		end else if (psel && penable && pwrite && paddr == ADDR_INV_DX_SQ) begin
			inv_q <= pwdata[CFG_W-1:0];
		end
	end

	assign adv          = !res.vld || out_ch.ready;
	assign in_ch.ready  = adv && !flush_q;
	assign acc          = in_ch.valid && in_ch.ready;
	assign fin          = in_ch.last || (pos_q == '1);

	always_comb begin
		issue = '0;
		if (acc) begin
			if (fin && pos_q < IDX_W'(DELAY)) begin
				issue.vld  = 1'b1;
				issue.kind = KIND_SHORT;
				issue.fin  = 1'b1;
			end else if (fin || pos_q >= IDX_W'(DELAY)) begin
				issue.vld  = 1'b1;
				issue.d    = SEL_W'(DELAY);
				issue.idx  = pos_q - IDX_W'(DELAY);
				issue.kind = kind_of(pos_q - IDX_W'(DELAY), fin ? 4'd6 : 4'd12);
			end
		end else if (flush_q && adv) begin
			issue.vld  = 1'b1;
			issue.d    = fd_q;
			issue.idx  = last_q - IDX_W'(fd_q);
			issue.kind = kind_of(last_q - IDX_W'(fd_q), {1'b0, fd_q});
			issue.fin  = (fd_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flush_q <= 1'b0;
			iss_s0  <= '0;
		end else begin
			if (adv)
				iss_s0 <= issue;
			if (acc) begin
				pos_q <= fin ? '0 : pos_q + 16'd1;
				if (fin && pos_q >= IDX_W'(DELAY))
					flush_q <= 1'b1;
			end else if (flush_q && adv && fd_q == '0) begin
				flush_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			last_q <= pos_q;
			fd_q   <= SEL_W'(DELAY - 1);
		end else if (flush_q && adv) begin
			fd_q <= fd_q - 3'd1;
		end
	end

	for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			sdf_cell u_cell (.clk(clk), .shift(acc), .d_in(in_ch.sample), .d_out(taps[g]));
		end else begin : g_body
			sdf_cell u_cell (.clk(clk), .shift(acc), .d_in(taps[g-1]), .d_out(taps[g]));
		end
	end

	sdf_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.iss(iss_s0),
		.taps(taps),
		.inv_dx_sq(inv_q),
		.res(res)
	);

	assign out_ch.valid     = res.vld;
	assign out_ch.deriv     = res.deriv;
	assign out_ch.index     = res.idx;
	assign out_ch.too_short = res.too_short;
	assign out_ch.final_res = res.fin;
endmodule

>>> src/sdf_checker.sv
// Port-level checks for the filter, bound to the top level.
`timescale 1ns / 1ps
module sdf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [sdf_pkg::DERIV_W-1:0] out_deriv,
	input logic [sdf_pkg::IDX_W-1:0]          out_index,
	input logic                               out_short,
	input logic                               out_final
);
	import sdf_pkg::*;

	a_short_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_short |-> out_deriv == '0 && out_index == '0 && out_final)
		else $error("too_short word with non-zero payload");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_deriv) && $stable(out_index))
		else $error("stalled output word changed");
endmodule

bind smooth_second_derivative_filter sdf_checker u_sdf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_deriv(out_ch.deriv),
	.out_index(out_ch.index),
	.out_short(out_ch.too_short),
	.out_final(out_ch.final_res)
);
